// ----- hdl/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg: shared types and constants of the life grid step core
// Request kinds, controller-to-datapath commands and datapath status.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int DEFAULT_MAX_SIDE = 64;

  localparam int KIND_W  = 2;
  localparam int COORD_W = 6;
  localparam int SIDE_W  = 7;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd1;
  localparam logic [OP_W-1:0] OP_ACCEPT  = 3'd2;
  localparam logic [OP_W-1:0] OP_EXEC    = 3'd3;
  localparam logic [OP_W-1:0] OP_ADV_ROW = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            finish;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic go_adv;
    logic row_last;
  } status_t;

endpackage

// ----- hdl/life_automaton_grid_step_core.sv -----
// ----------------------------------------------------------------------------
// life_automaton_grid_step_core: B3/S23 life grid with cell access
// Square grid of one-bit cells; write cell, read cell, advance one generation.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Busy stays high
// while a cell write or read runs and, for an advance, while the active
// rows are rewritten one by one, since the grid memory holds one row per
// word and one row of the new generation is written each cycle. The result
// appears on done for exactly one cycle, the first cycle with busy low
// again, and the receiver cannot stall it. After reset the core makes a
// clearing pass over every row of the grid memory with busy high; side_in_use
// writes are taken at any time (cfg_ready is always high) but should be
// made while idle.
module life_automaton_grid_step_core #(
  parameter int MAX_SIDE = lgs_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [lgs_pkg::KIND_W-1:0]   kind,
  input  logic [lgs_pkg::COORD_W-1:0]  column,
  input  logic [lgs_pkg::COORD_W-1:0]  row,
  input  logic                         cell_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lgs_pkg::SIDE_W-1:0]   side_in_use,
  output logic                         done,
  output logic                         read_value,
  output logic [lgs_pkg::KIND_W-1:0]   done_kind,
  output logic                         out_of_range
);

  lgs_pkg::cmd_t    cmd;
  lgs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  lgs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  lgs_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .kind         (kind),
    .column       (column),
    .row          (row),
    .cell_value   (cell_value),
    .cfg_write    (cfg_valid),
    .side_in_use  (side_in_use),
    .done         (done),
    .read_value   (read_value),
    .done_kind    (done_kind),
    .out_of_range (out_of_range)
  );

endmodule

// ----- hdl/lgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lgs_ctrl: sequencer of the life grid step core
// Runs the clearing pass, accepts requests and steps an advance row by row.
// ----------------------------------------------------------------------------
module lgs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output lgs_pkg::cmd_t    cmd,
  input  lgs_pkg::status_t status
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_ADV   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = lgs_pkg::OP_NONE;
    cmd.finish = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = lgs_pkg::OP_CLEAR;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op     = lgs_pkg::OP_ACCEPT;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.op = lgs_pkg::OP_EXEC;
        if (status.go_adv) begin
          state_next = ST_ADV;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_ADV: begin
        cmd.op = lgs_pkg::OP_ADV_ROW;
        if (status.row_last) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

// ----- hdl/lgs_datapath.sv -----
// ----------------------------------------------------------------------------
// lgs_datapath: row memory, row buffers and neighbor logic
// The grid is stored one row per memory word; an advance rewrites one row
// per cycle from a three-row window of the old generation.
// ----------------------------------------------------------------------------
module lgs_datapath #(
  parameter int MAX_SIDE = lgs_pkg::DEFAULT_MAX_SIDE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lgs_pkg::cmd_t                cmd,
  output lgs_pkg::status_t             status,
  input  logic [lgs_pkg::KIND_W-1:0]   kind,
  input  logic [lgs_pkg::COORD_W-1:0]  column,
  input  logic [lgs_pkg::COORD_W-1:0]  row,
  input  logic                         cell_value,
  input  logic                         cfg_write,
  input  logic [lgs_pkg::SIDE_W-1:0]   side_in_use,
  output logic                         done,
  output logic                         read_value,
  output logic [lgs_pkg::KIND_W-1:0]   done_kind,
  output logic                         out_of_range
);

  localparam int ROW_W     = $clog2(MAX_SIDE);
  localparam int CNT_W     = ((ROW_W > lgs_pkg::SIDE_W) ? ROW_W : lgs_pkg::SIDE_W) + 1;
  localparam int SIDE_MAXV = (1 << lgs_pkg::SIDE_W) - 1;
  localparam logic [lgs_pkg::SIDE_W-1:0] SIDE_CAP =
    lgs_pkg::SIDE_W'((MAX_SIDE > SIDE_MAXV) ? SIDE_MAXV : MAX_SIDE);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_SIDE - 1);

  logic [MAX_SIDE-1:0] grid_mem [MAX_SIDE];

  logic [lgs_pkg::SIDE_W-1:0]  side_reg;
  logic [lgs_pkg::SIDE_W-1:0]  eff_side;
  logic [lgs_pkg::KIND_W-1:0]  req_kind;
  logic [lgs_pkg::COORD_W-1:0] req_row;
  logic [lgs_pkg::COORD_W-1:0] req_col;
  logic                        req_value;
  logic                        req_oor;
  logic                        acc_oor;
  logic [ROW_W-1:0]            row_cnt;
  logic [ROW_W-1:0]            col_idx;
  logic [MAX_SIDE-1:0]         rd_row;
  logic [MAX_SIDE-1:0]         prev_row;
  logic [MAX_SIDE-1:0]         cur_row;
  logic [MAX_SIDE-1:0]         col_mask;
  logic [MAX_SIDE-1:0]         new_row;
  logic [ROW_W-1:0]            rd_addr;
  logic [ROW_W-1:0]            wr_addr;
  logic [MAX_SIDE-1:0]         wr_data;
  logic                        wr_en;
  logic                        row_last;

  assign eff_side = (side_reg > SIDE_CAP) ? SIDE_CAP : side_reg;
  assign col_idx  = ROW_W'(req_col);
  assign row_last = ((CNT_W'(row_cnt) + CNT_W'(1)) == CNT_W'(eff_side));

  assign acc_oor = ((kind == lgs_pkg::KIND_WRITE) || (kind == lgs_pkg::KIND_READ)) &&
                   ((lgs_pkg::SIDE_W'(row) >= eff_side) ||
                    (lgs_pkg::SIDE_W'(column) >= eff_side));

  assign status.clear_last = (row_cnt == LAST_ROW);
  assign status.go_adv     = (req_kind == lgs_pkg::KIND_ADVANCE) && (eff_side != '0);
  assign status.row_last   = row_last;

  // columns outside the active square count as dead
  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      col_mask[c] = (int'(eff_side) > c);
    end
  end

  // next generation of the row held in cur_row
  always_comb begin
    logic [MAX_SIDE+1:0] pp;
    logic [MAX_SIDE+1:0] cc;
    logic [MAX_SIDE+1:0] nn;
    logic [3:0]          cnt;
    logic                nxt;
    pp = {1'b0, prev_row & col_mask, 1'b0};
    cc = {1'b0, cur_row & col_mask, 1'b0};
    nn = row_last ? '0 : {1'b0, rd_row & col_mask, 1'b0};
    for (int j = 0; j < MAX_SIDE; j++) begin
      cnt = 4'(pp[j]) + 4'(pp[j+1]) + 4'(pp[j+2]) +
            4'(cc[j]) + 4'(cc[j+2]) +
            4'(nn[j]) + 4'(nn[j+1]) + 4'(nn[j+2]);
      if (cc[j+1]) begin
        nxt = (cnt == lgs_pkg::SURVIVE_LOW) || (cnt == lgs_pkg::BIRTH_COUNT);
      end else begin
        nxt = (cnt == lgs_pkg::BIRTH_COUNT);
      end
      new_row[j] = col_mask[j] ? nxt : cur_row[j];
    end
  end

  always_comb begin
    rd_addr = ROW_W'(CNT_W'(row_cnt) + CNT_W'(2));
    wr_addr = row_cnt;
    wr_data = new_row;
    wr_en   = 1'b0;
    unique case (cmd.op)
      lgs_pkg::OP_NONE: begin
      end
      lgs_pkg::OP_CLEAR: begin
        wr_data = '0;
        wr_en   = 1'b1;
      end
      lgs_pkg::OP_ACCEPT: begin
        rd_addr = (kind == lgs_pkg::KIND_ADVANCE) ? '0 : ROW_W'(row);
      end
      lgs_pkg::OP_EXEC: begin
        rd_addr          = ROW_W'(1);
        wr_addr          = ROW_W'(req_row);
        wr_data          = rd_row;
        wr_data[col_idx] = req_value;
        wr_en            = (req_kind == lgs_pkg::KIND_WRITE) && !req_oor;
      end
      lgs_pkg::OP_ADV_ROW: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) grid_mem[wr_addr] <= wr_data;
    rd_row <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg <= lgs_pkg::SIDE_RESET;
    end else if (cfg_write) begin
      side_reg <= side_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
    end else begin
      unique case (cmd.op)
        lgs_pkg::OP_CLEAR: row_cnt <= status.clear_last ? '0 : row_cnt + ROW_W'(1);
        lgs_pkg::OP_EXEC:  row_cnt <= '0;
        lgs_pkg::OP_ADV_ROW: row_cnt <= row_cnt + ROW_W'(1);
        default: row_cnt <= row_cnt;
      endcase
    end
  end

  // hold the request and slide the three-row window
  always_ff @(posedge clk) begin
    if (cmd.op == lgs_pkg::OP_ACCEPT) begin
      req_kind  <= kind;
      req_row   <= row;
      req_col   <= column;
      req_value <= cell_value;
      req_oor   <= acc_oor;
    end
    if (cmd.op == lgs_pkg::OP_EXEC) begin
      prev_row <= '0;
      cur_row  <= rd_row;
    end else if (cmd.op == lgs_pkg::OP_ADV_ROW) begin
      prev_row <= cur_row;
      cur_row  <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value   <= (req_kind == lgs_pkg::KIND_READ) && !req_oor && rd_row[col_idx];
      done_kind    <= req_kind;
      out_of_range <= req_oor;
    end
  end

endmodule

// ----- hdl/lgs_checker.sv -----
// ----------------------------------------------------------------------------
// lgs_checker: port-level checks of the life grid step core
// Request/result ordering and result field consistency.
// ----------------------------------------------------------------------------
module lgs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       read_value,
  input logic [lgs_pkg::KIND_W-1:0] done_kind,
  input logic                       out_of_range
);

  // a taken request makes the core busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request taken but core not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !done)
    else $error("result while idle");

  a_advance_fields: assert property (@(posedge clk) disable iff (rst)
    done && (done_kind == lgs_pkg::KIND_ADVANCE) |-> !read_value && !out_of_range)
    else $error("advance result carries cell fields");

  a_oor_no_read: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> !read_value)
    else $error("ignored access returned a live cell");

endmodule

bind life_automaton_grid_step_core lgs_checker u_lgs_checker (.*);
